// ===== design/polygon_perimeter_macros.svh =====
// ---------------------------------------------------------------------------
// Polygon perimeter assertion macros
// Concurrent assertion wrappers that vanish when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef POLYGON_PERIMETER_MACROS_SVH
`define POLYGON_PERIMETER_MACROS_SVH

`ifndef SYNTHESIS
`define PP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define PP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PP_ASSERT(lbl, prop, msg)
`define PP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== design/pp_pkg.sv =====
// ---------------------------------------------------------------------------
// Polygon perimeter package
// Sequencer states, field widths and saturation limits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pp_pkg;

  localparam int COORD_W = 16;
  localparam int SUM_W   = 48;
  localparam int COUNT_W = 16;
  localparam int ROOT_W  = 25;
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int REM_W   = ROOT_W + 1;
  localparam int STEP_W  = 5;

  localparam logic [STEP_W-1:0]  STEP_LAST = STEP_W'(ROOT_W - 1);
  localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQX,
    ST_SQY,
    ST_ROOT,
    ST_ACCUM,
    ST_OUT
  } state_t;

endpackage

// ===== design/polygon_perimeter.sv =====
// ---------------------------------------------------------------------------
// Polygon perimeter
// Sequence: an opening vertex that is not final only seeds the polygon; any other
// vertex runs difference, two squarings on one shared 16x16 multiplier, a 25-step
// square root and accumulate. A final vertex runs the sequence again for the closing
// edge; a lone vertex runs it once. The perimeter is registered once the output
// register is free and the input reopens after that; output stalls can hold both up.
// Reset (rst, synchronous) clears the sequencer, polygon state and output valid.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "polygon_perimeter_macros.svh"

module polygon_perimeter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [pp_pkg::COORD_W-1:0]   x_coord,
  input  logic signed [pp_pkg::COORD_W-1:0]   y_coord,
  input  logic                                last_vertex,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic        [pp_pkg::SUM_W-1:0]     perimeter,
  output logic        [pp_pkg::COUNT_W-1:0]   vertex_count
);

  import pp_pkg::*;

  // Sequencer state.
  state_t state;
  state_t state_next;

  // Polygon state kept between requests.
  logic [COORD_W-1:0] first_x;
  logic [COORD_W-1:0] first_y;
  logic [COORD_W-1:0] prev_x;
  logic [COORD_W-1:0] prev_y;
  logic               in_polygon;
  logic [SUM_W-1:0]   length_sum;
  logic [COUNT_W-1:0] count_seen;
  logic               last_r;
  logic               closing;

  // Edge end points and the working registers of the shared datapath.
  logic [COORD_W-1:0] ea_x;
  logic [COORD_W-1:0] ea_y;
  logic [COORD_W-1:0] eb_x;
  logic [COORD_W-1:0] eb_y;
  logic [COORD_W-1:0] ux;
  logic [COORD_W-1:0] uy;
  logic [2*COORD_W-1:0] sq_x;
  logic [RAD_W-1:0]   rad;
  logic [REM_W-1:0]   rem;
  logic [ROOT_W-1:0]  root;
  logic [STEP_W-1:0]  step;

  // Decoded controls.
  logic accept;
  logic out_free;
  logic out_load;
  logic mul_sel_y;

  // Combinational datapath.
  logic [COORD_W:0]     dx;
  logic [COORD_W:0]     dy;
  logic [COORD_W:0]     ndx;
  logic [COORD_W:0]     ndy;
  logic [COORD_W-1:0]   mul_op;
  logic [2*COORD_W-1:0] prod;
  logic [2*COORD_W:0]   sq_sum;
  logic [REM_W+1:0]     rt_shift;
  logic [REM_W+1:0]     rt_trial;
  logic [REM_W+1:0]     rt_diff;
  logic                 rt_ge;
  logic [SUM_W:0]       sum_wide;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (in_polygon || last_vertex)) begin
          state_next = ST_DIFF;
        end
      end
      ST_DIFF:  state_next = ST_SQX;
      ST_SQX:   state_next = ST_SQY;
      ST_SQY:   state_next = ST_ROOT;
      ST_ROOT: begin
        if (step == STEP_LAST) begin
          state_next = ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        if (closing) begin
          state_next = ST_OUT;
        end else if (last_r) begin
          state_next = ST_DIFF;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer. The output register is free when it is
  // empty or its content is taken in this cycle, so a waiting result never
  // holds up the input side until the next one is ready.
  always_comb begin
    in_stall  = 1'b1;
    mul_sel_y = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      ST_IDLE:  in_stall  = 1'b0;
      ST_SQY:   mul_sel_y = 1'b1;
      ST_OUT:   out_load  = out_free;
      default:  in_stall  = 1'b1;
    endcase
  end

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Absolute coordinate differences, 17-bit signed, magnitude fits 16 bits.
  assign dx  = {ea_x[COORD_W-1], ea_x} - {eb_x[COORD_W-1], eb_x};
  assign dy  = {ea_y[COORD_W-1], ea_y} - {eb_y[COORD_W-1], eb_y};
  assign ndx = (COORD_W+1)'(0) - dx;
  assign ndy = (COORD_W+1)'(0) - dy;

  // The single multiplier squares ux, then uy.
  assign mul_op = mul_sel_y ? uy : ux;
  assign prod   = mul_op * mul_op;
  assign sq_sum = {1'b0, sq_x} + {1'b0, prod};

  // One restoring square-root digit: bring down two radicand bits and try
  // subtracting 4*root + 1.
  assign rt_shift = {rem, rad[RAD_W-1 -: 2]};
  assign rt_trial = {1'b0, root, 2'b01};
  assign rt_ge    = (rt_shift >= rt_trial);
  assign rt_diff  = rt_shift - rt_trial;

  // Saturating perimeter accumulation.
  assign sum_wide = {1'b0, length_sum} + (SUM_W+1)'(root);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      in_polygon <= 1'b0;
      length_sum <= '0;
      count_seen <= '0;
      first_x    <= '0;
      first_y    <= '0;
      prev_x     <= '0;
      prev_y     <= '0;
      closing    <= 1'b0;
      last_r     <= 1'b0;
      step       <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            last_r <= last_vertex;
            prev_x <= x_coord;
            prev_y <= y_coord;
            eb_x   <= x_coord;
            eb_y   <= y_coord;
            if (!in_polygon) begin
              // Opening vertex: a closing edge to itself has zero length.
              first_x    <= x_coord;
              first_y    <= y_coord;
              length_sum <= '0;
              count_seen <= COUNT_W'(1);
              in_polygon <= 1'b1;
              ea_x       <= x_coord;
              ea_y       <= y_coord;
              closing    <= 1'b1;
            end else begin
              ea_x    <= prev_x;
              ea_y    <= prev_y;
              closing <= 1'b0;
              if (count_seen != COUNT_MAX) begin
                count_seen <= count_seen + COUNT_W'(1);
              end
            end
          end
        end
        ST_DIFF: begin
          ux <= dx[COORD_W] ? ndx[COORD_W-1:0] : dx[COORD_W-1:0];
          uy <= dy[COORD_W] ? ndy[COORD_W-1:0] : dy[COORD_W-1:0];
        end
        ST_SQX: begin
          sq_x <= prod;
        end
        ST_SQY: begin
          rad  <= {1'b0, sq_sum, 16'h0000};
          rem  <= '0;
          root <= '0;
          step <= '0;
        end
        ST_ROOT: begin
          rad  <= {rad[RAD_W-3:0], 2'b00};
          rem  <= rt_ge ? rt_diff[REM_W-1:0] : rt_shift[REM_W-1:0];
          root <= {root[ROOT_W-2:0], rt_ge};
          step <= (step == STEP_LAST) ? '0 : step + STEP_W'(1);
        end
        ST_ACCUM: begin
          length_sum <= sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
          if (!closing && last_r) begin
            // Closing edge from the final vertex back to the first.
            ea_x    <= prev_x;
            ea_y    <= prev_y;
            eb_x    <= first_x;
            eb_y    <= first_y;
            closing <= 1'b1;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            in_polygon <= 1'b0;
            length_sum <= '0;
            count_seen <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result register: payload only, qualified by out_valid.
  always_ff @(posedge clk) begin
    if (out_load) begin
      perimeter    <= length_sum;
      vertex_count <= count_seen;
    end
  end

  `PP_ASSERT(a_result_from_seq, $rose(out_valid) |-> ($past(state) == ST_OUT), "result not from sequencer")
  `PP_ASSERT(a_step_range, step <= STEP_LAST, "root step counter out of range")
  `PP_ASSERT(a_count_live, !in_polygon || (count_seen != '0), "open polygon with zero count")
  `PP_ASSERT_NEXT(a_open_fast, accept && !in_polygon && !last_vertex, state == ST_IDLE, "opening vertex not taken in one cycle")

endmodule

// ===== dv/testbench.sv =====
// ---------------------------------------------------------------------------
// Polygon perimeter testbench
// Streams closed polygons into the perimeter block and checks each perimeter
// and vertex count against a cycle-free model of the arithmetic. Directed
// polygons come first, then random ones. Both sides of the block idle at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import pp_pkg::*;

  // A run with every vertex closing a polygon, the longest sender gaps and
  // the longest output stalls stays well under a third of this.
  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int RANDOM_TARGET = 1350;
  // Settling time after the last perimeter.
  localparam int DRAIN_CYCLES  = 100;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      last;
    logic                      hold;   // wait for all perimeters before sending
  } vertex_t;

  typedef struct {
    logic [SUM_W-1:0]   perimeter;
    logic [COUNT_W-1:0] count;
  } total_t;

  logic                      clk          = 1'b0;
  logic                      rst          = 1'b1;
  logic                      in_valid     = 1'b0;
  logic                      in_stall;
  logic signed [COORD_W-1:0] x_coord      = '0;
  logic signed [COORD_W-1:0] y_coord      = '0;
  logic                      last_vertex  = 1'b0;
  logic                      out_valid;
  logic                      out_stall    = 1'b0;
  logic [SUM_W-1:0]          perimeter;
  logic [COUNT_W-1:0]        vertex_count;

  vertex_t pending_vertices[$];
  total_t  expected_totals[$];

  logic vertex_taken = 1'b0;
  int   mismatches   = 0;
  int   cycles       = 0;

  // Sender and receiver pacing, owned by the negative-edge blocks.
  int send_gap    = 0;
  int calm_sends  = 0;
  int stall_left  = 0;
  int calm_cycles = 0;

  // Shadow of the block's polygon state.
  logic                      poly_open  = 1'b0;
  logic signed [COORD_W-1:0] first_x    = '0;
  logic signed [COORD_W-1:0] first_y    = '0;
  logic signed [COORD_W-1:0] prior_x    = '0;
  logic signed [COORD_W-1:0] prior_y    = '0;
  longint unsigned           open_length = 0;
  logic [COUNT_W-1:0]        open_count  = '0;

  polygon_perimeter uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .x_coord      (x_coord),
    .y_coord      (y_coord),
    .last_vertex  (last_vertex),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .perimeter    (perimeter),
    .vertex_count (vertex_count)
  );

  always #5 clk = ~clk;

  // -------------------------------------------------------------------------
  // Arithmetic of one edge
  // -------------------------------------------------------------------------

  // Floor of the square root, built one result bit at a time from the top.
  // The radicand is below 2^50, so 26 result bits are plenty and the trial
  // square never leaves 64 bits.
  function automatic longint unsigned floor_root(longint unsigned radicand);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 25; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= radicand) root = trial;
    end
    return root;
  endfunction

  // Euclidean distance between two vertices with 8 fractional bits: the
  // squared distance is scaled by 2^16 before the root is taken.
  function automatic longint unsigned edge_length(logic signed [COORD_W-1:0] ax,
                                                  logic signed [COORD_W-1:0] ay,
                                                  logic signed [COORD_W-1:0] bx,
                                                  logic signed [COORD_W-1:0] by);
    longint dx;
    longint dy;
    longint unsigned squared;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    squared = longint'(dx * dx + dy * dy);
    return floor_root(squared << 16);
  endfunction

  // The running sum sticks at its maximum rather than wrapping.
  function automatic longint unsigned add_capped(longint unsigned sum, longint unsigned len);
    longint unsigned total;
    total = sum + len;
    return (total > longint'(SUM_MAX)) ? longint'(SUM_MAX) : total;
  endfunction

  // -------------------------------------------------------------------------
  // Predictor: follows one accepted vertex and queues the perimeter that a
  // final vertex produces.
  // -------------------------------------------------------------------------
  task automatic track_vertex(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                              logic last);
    total_t done;
    if (!poly_open) begin
      // The opening vertex only seeds the polygon.
      first_x     = x;
      first_y     = y;
      open_length = 0;
      open_count  = 1;
      poly_open   = 1'b1;
    end else begin
      open_length = add_capped(open_length, edge_length(prior_x, prior_y, x, y));
      if (open_count != COUNT_MAX) open_count = open_count + 1'b1;
    end
    prior_x = x;
    prior_y = y;
    if (last) begin
      // Close the loop back to the opening vertex and start afresh.
      open_length    = add_capped(open_length, edge_length(x, y, first_x, first_y));
      done.perimeter = open_length[SUM_W-1:0];
      done.count     = open_count;
      expected_totals.push_back(done);
      poly_open   = 1'b0;
      open_length = 0;
      open_count  = '0;
    end
  endtask

  task automatic flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // -------------------------------------------------------------------------
  // Stimulus construction
  // -------------------------------------------------------------------------
  task automatic add_vertex(int x, int y, logic last, logic hold = 1'b0);
    vertex_t v;
    v.x    = COORD_W'(x);
    v.y    = COORD_W'(y);
    v.last = last;
    v.hold = hold;
    pending_vertices.push_back(v);
  endtask

  // Coordinates come in several flavours so that long and short edges, the
  // extremes of the range and every single bit all turn up.
  function automatic logic signed [COORD_W-1:0] draw_coord(logic signed [COORD_W-1:0] near);
    int roll;
    int corner;
    roll = $urandom_range(99);
    if (roll < 40) return COORD_W'($urandom);
    if (roll < 65) return COORD_W'($urandom_range(127) - 64);
    if (roll < 85) return near + COORD_W'($urandom_range(511) - 256);
    corner = $urandom_range(6);
    case (corner)
      0:       return -16'sd32768;
      1:       return -16'sd32767;
      2:       return -16'sd1;
      3:       return 16'sd0;
      4:       return 16'sd1;
      5:       return 16'sd32766;
      default: return 16'sd32767;
    endcase
  endfunction

  // Mostly no gap or a short one, now and then a long one.
  function automatic int draw_gap(int long_max);
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(5, 1);
    if (roll < 97) return $urandom_range(40, 6);
    return $urandom_range(long_max, 41);
  endfunction

  // -------------------------------------------------------------------------
  // Driver: presents the next request at the falling edge once the previous
  // one has been taken and any gap has run out.
  // -------------------------------------------------------------------------
  always @(negedge clk) begin : drive_vertices
    vertex_t v;
    logic    next_valid;
    next_valid = in_valid;
    if (rst) begin
      next_valid = 1'b0;
    end else begin
      if (in_valid && vertex_taken) next_valid = 1'b0;
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_vertices.size() != 0 &&
                     !(pending_vertices[0].hold && expected_totals.size() != 0)) begin
          v = pending_vertices.pop_front();
          x_coord     <= v.x;
          y_coord     <= v.y;
          last_vertex <= v.last;
          next_valid  = 1'b1;
          // Plan the gap after this request; a calm stretch sends back to back.
          if (calm_sends > 0) begin
            calm_sends--;
            send_gap = 0;
          end else begin
            send_gap = draw_gap(100);
            if ($urandom_range(49) == 0) calm_sends = $urandom_range(60, 20);
          end
        end
      end
    end
    in_valid <= next_valid;
  end

  // Output stall: runs of random length with occasional long stall-free spells.
  always @(negedge clk) begin : drive_stall
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (calm_cycles > 0) begin
      calm_cycles--;
      out_stall <= 1'b0;
    end else begin
      stall_left = draw_gap(60);
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
      else if ($urandom_range(199) == 0) calm_cycles = $urandom_range(400, 100);
    end
  end

  // -------------------------------------------------------------------------
  // Monitor: everything is sampled at the rising edge, when both handshakes
  // resolve.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin : watch_ports
    total_t want;
    vertex_taken <= in_valid && !in_stall && !rst;
    if (!rst) begin
      if (in_valid && !in_stall) track_vertex(x_coord, y_coord, last_vertex);
      if (out_valid && !out_stall) begin
        if (expected_totals.size() == 0) begin
          flag_mismatch($sformatf("unexpected result: perimeter %0d count %0d",
                                  perimeter, vertex_count));
        end else begin
          want = expected_totals.pop_front();
          if (perimeter !== want.perimeter)
            flag_mismatch($sformatf("perimeter: expected %0d, got %0d",
                                    want.perimeter, perimeter));
          if (vertex_count !== want.count)
            flag_mismatch($sformatf("vertex_count: expected %0d, got %0d",
                                    want.count, vertex_count));
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin : watchdog
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Test sequence
  // -------------------------------------------------------------------------
  initial begin : run_test
    int queued;
    int sides;
    int roll;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;

    // A lone vertex closes onto itself, giving a perimeter of zero.
    add_vertex(0, 0, 1'b1);
    add_vertex(-32768, 32767, 1'b1);
    // Two vertices: the single edge is walked out and back. This pair is the
    // longest edge the coordinates allow.
    add_vertex(-32768, -32768, 1'b0);
    add_vertex(32767, 32767, 1'b1);
    // Two coincident vertices.
    add_vertex(123, -456, 1'b0);
    add_vertex(123, -456, 1'b1);
    // A 3-4-5 triangle, whose sides are whole numbers.
    add_vertex(0, 0, 1'b0);
    add_vertex(3, 0, 1'b0);
    add_vertex(0, 4, 1'b1);
    // The full square of the coordinate range.
    add_vertex(-32768, -32768, 1'b0);
    add_vertex(32767, -32768, 1'b0);
    add_vertex(32767, 32767, 1'b0);
    add_vertex(-32768, 32767, 1'b1);
    // A purely horizontal edge running in the negative direction.
    add_vertex(32767, 0, 1'b0);
    add_vertex(-32768, 0, 1'b1);
    // An irregular shape with edges in every quadrant.
    add_vertex(1, 1, 1'b0);
    add_vertex(2, 2, 1'b0);
    add_vertex(-1, -3, 1'b0);
    add_vertex(5, -7, 1'b0);
    add_vertex(32767, -1, 1'b1);

    // Random polygons. The first waits until the directed ones have all
    // drained, and now and then another does the same.
    queued = 0;
    cx = '0;
    cy = '0;
    while (queued < RANDOM_TARGET) begin
      roll = $urandom_range(99);
      if (roll < 15)      sides = 1;
      else if (roll < 30) sides = 2;
      else if (roll < 85) sides = $urandom_range(12, 3);
      else                sides = $urandom_range(60, 13);
      for (int i = 0; i < sides; i++) begin
        cx = draw_coord(cx);
        cy = draw_coord(cy);
        add_vertex(cx, cy, i == sides - 1,
                   i == 0 && (queued == 0 || $urandom_range(39) == 0));
      end
      queued += sides;
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Let every request go in, then every perimeter come out, then allow
    // the block a little time to show anything spurious.
    while (pending_vertices.size() != 0 || in_valid) @(posedge clk);
    while (expected_totals.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
